/* src/fra_pkg.sv */
package fra_pkg;

   // default magnitude width of each numerator and denominator
   localparam int VALUE_BITS_DEF = 16;

   // operation codes of the shared gcd / divide unit
   typedef enum logic {
      FRA_OP_GCD = 1'b0,
      FRA_OP_DIV = 1'b1
   } fra_op_type;

   // command from the sequencer to the shared unit
   typedef struct packed {
      logic       start;
      fra_op_type op;
      logic       short_op;
   } fra_unit_cmd_type;

   // status from the shared unit back to the sequencer
   typedef struct packed {
      logic done;
   } fra_unit_sts_type;

endpackage

/* src/fra_req_if.sv */
interface fra_req_if
   import fra_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] num_first;
   logic [VALUE_BITS-1:0] den_first;
   logic [VALUE_BITS-1:0] num_second;
   logic [VALUE_BITS-1:0] den_second;

   modport source (
      output valid, num_first, den_first, num_second, den_second,
      input  ready
   );

   modport sink (
      input  valid, num_first, den_first, num_second, den_second,
      output ready
   );
endinterface

/* src/fra_rsp_if.sv */
interface fra_rsp_if
   import fra_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [2*VALUE_BITS:0]   sum_num;
   logic [2*VALUE_BITS-1:0] sum_den;

   modport source (
      output valid, sum_num, sum_den,
      input  ready
   );

   modport sink (
      input  valid, sum_num, sum_den,
      output ready
   );
endinterface

/* src/fraction_add_reduce_top.sv */
// Fraction adder with full reduction. Each request transaction carries two
// fractions num_first/den_first and num_second/den_second (unsigned, a zero
// denominator is taken as 1); the response transaction carries sum_num/sum_den,
// the sum reduced to lowest terms, with 0/1 for a zero sum. All the gcd and
// division work runs through one shared unit with a single subtractor and a
// negator that does one binary-gcd step or one restoring-division bit per
// cycle, under a small sequencer; a single multiplier forms the lcm and both
// scaled numerators. One transaction is worked at a time and req_port.ready is
// low meanwhile. The number of gcd steps depends on the values; the gcd of the
// full-width sum and lcm and the two divisions by it dominate the work, and a
// zero sum skips all three. The result sits in an output register, so the next
// request is taken while the previous response waits.
module fraction_add_reduce_top
   import fra_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input logic             clock,
   input logic             reset,
   fra_req_if.sink         req_port,
   fra_rsp_if.source       rsp_port
);

   localparam int NumW = 2 * VALUE_BITS + 1;
   localparam int DenW = 2 * VALUE_BITS;

   // sequencer states, one-hot
   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_G1   = 13'b0000000000010, // gcd of the denominators
      S_DB   = 13'b0000000000100, // first denominator over gcd
      S_DD   = 13'b0000000001000, // second denominator over gcd
      S_M1   = 13'b0000000010000, // lcm product
      S_M2   = 13'b0000000100000, // first scaled numerator
      S_M3   = 13'b0000001000000, // second scaled numerator
      S_ADD  = 13'b0000010000000, // numerator sum
      S_ZCHK = 13'b0000100000000, // zero sum short cut
      S_G2   = 13'b0001000000000, // gcd of sum and lcm
      S_DS   = 13'b0010000000000, // sum over gcd
      S_DL   = 13'b0100000000000, // lcm over gcd
      S_OUT  = 13'b1000000000000  // hand result to output register
   } fra_state_type;

   fra_state_type         state_ff, state_in;
   logic                  start_ff, start_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [VALUE_BITS-1:0] a_ff, a_in;
   logic [VALUE_BITS-1:0] b_ff, b_in;
   logic [VALUE_BITS-1:0] c_ff, c_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [VALUE_BITS-1:0] bpart_ff, bpart_in;
   logic [VALUE_BITS-1:0] dpart_ff, dpart_in;
   logic [NumW-1:0]       gcd_ff, gcd_in;
   logic [NumW-1:0]       sum_ff, sum_in;
   logic [DenW-1:0]       lcm_ff, lcm_in;
   logic [DenW-1:0]       prod_ff, prod_in;
   logic [NumW-1:0]       rsp_num_ff, rsp_num_in;
   logic [DenW-1:0]       rsp_den_ff, rsp_den_in;

   logic [VALUE_BITS-1:0] mul_a, mul_b;
   fra_unit_cmd_type      unit_cmd;
   fra_unit_sts_type      unit_sts;
   logic [NumW-1:0]       unit_opa, unit_opb;
   logic [NumW-1:0]       unit_result;
   logic                  req_take;
   logic                  out_load;

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_take       = req_port.valid && (state_ff == S_IDLE);
   // output register frees when empty or being drained this cycle
   assign out_load       = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_port.ready);

   // operand selection for the shared unit
   always_comb begin
      unit_cmd.start    = start_ff;
      unit_cmd.op       = FRA_OP_GCD;
      unit_cmd.short_op = 1'b0;
      unit_opa          = '0;
      unit_opb          = '0;
      unique case (state_ff)
         S_G1: begin
            unit_opa = NumW'(b_ff);
            unit_opb = NumW'(d_ff);
         end
         S_DB: begin
            unit_cmd.op       = FRA_OP_DIV;
            unit_cmd.short_op = 1'b1;
            unit_opa          = NumW'(b_ff);
            unit_opb          = gcd_ff;
         end
         S_DD: begin
            unit_cmd.op       = FRA_OP_DIV;
            unit_cmd.short_op = 1'b1;
            unit_opa          = NumW'(d_ff);
            unit_opb          = gcd_ff;
         end
         S_G2: begin
            unit_opa = sum_ff;
            unit_opb = NumW'(lcm_ff);
         end
         S_DS: begin
            unit_cmd.op = FRA_OP_DIV;
            unit_opa    = sum_ff;
            unit_opb    = gcd_ff;
         end
         S_DL: begin
            unit_cmd.op = FRA_OP_DIV;
            unit_opa    = NumW'(lcm_ff);
            unit_opb    = gcd_ff;
         end
         default: begin
            unit_opa = '0;
         end
      endcase
   end

   // the one multiplier, registered every cycle
   always_comb begin
      unique case (state_ff)
         S_M2: begin
            mul_a = a_ff;
            mul_b = dpart_ff;
         end
         S_M3: begin
            mul_a = c_ff;
            mul_b = bpart_ff;
         end
         default: begin
            mul_a = bpart_ff;
            mul_b = d_ff;
         end
      endcase
   end

   assign prod_in = DenW'(mul_a) * DenW'(mul_b);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      bpart_in     = bpart_ff;
      dpart_in     = dpart_ff;
      gcd_in       = gcd_ff;
      sum_in       = sum_ff;
      lcm_in       = lcm_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               a_in     = req_port.num_first;
               c_in     = req_port.num_second;
               // zero denominator stands for one
               b_in     = (req_port.den_first == '0) ? VALUE_BITS'(1) : req_port.den_first;
               d_in     = (req_port.den_second == '0) ? VALUE_BITS'(1) : req_port.den_second;
               state_in = S_G1;
               start_in = 1'b1;
            end
         end
         S_G1: begin
            if (unit_sts.done) begin
               gcd_in   = unit_result;
               state_in = S_DB;
               start_in = 1'b1;
            end
         end
         S_DB: begin
            if (unit_sts.done) begin
               bpart_in = unit_result[VALUE_BITS-1:0];
               state_in = S_DD;
               start_in = 1'b1;
            end
         end
         S_DD: begin
            if (unit_sts.done) begin
               dpart_in = unit_result[VALUE_BITS-1:0];
               state_in = S_M1;
            end
         end
         S_M1: begin
            state_in = S_M2;
         end
         S_M2: begin
            lcm_in   = prod_ff;
            state_in = S_M3;
         end
         S_M3: begin
            sum_in   = NumW'(prod_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            sum_in   = sum_ff + NumW'(prod_ff);
            state_in = S_ZCHK;
         end
         S_ZCHK: begin
            if (sum_ff == '0) begin
               lcm_in   = DenW'(1);
               state_in = S_OUT;
            end else begin
               state_in = S_G2;
               start_in = 1'b1;
            end
         end
         S_G2: begin
            if (unit_sts.done) begin
               gcd_in   = unit_result;
               state_in = S_DS;
               start_in = 1'b1;
            end
         end
         S_DS: begin
            if (unit_sts.done) begin
               sum_in   = unit_result;
               state_in = S_DL;
               start_in = 1'b1;
            end
         end
         S_DL: begin
            if (unit_sts.done) begin
               lcm_in   = unit_result[DenW-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_num_in   = sum_ff;
               rsp_den_in   = lcm_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      d_ff       <= d_in;
      bpart_ff   <= bpart_in;
      dpart_ff   <= dpart_in;
      gcd_ff     <= gcd_in;
      sum_ff     <= sum_in;
      lcm_ff     <= lcm_in;
      prod_ff    <= prod_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   fra_unit #(
      .VALUE_BITS (VALUE_BITS)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .opa    (unit_opa),
      .opb    (unit_opb),
      .sts    (unit_sts),
      .result (unit_result)
   );

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.sum_num = rsp_num_ff;
   assign rsp_port.sum_den = rsp_den_ff;

`ifndef SYNTHESIS
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_G1 && start_ff))
      else $error("accepted transaction did not start the gcd");

   a_start_state: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == S_G1 || state_ff == S_DB || state_ff == S_DD ||
                    state_ff == S_G2 || state_ff == S_DS || state_ff == S_DL))
      else $error("unit started outside a unit state");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_den_ff != '0)
      else $error("zero denominator in response");
`endif

endmodule

/* src/fra_unit.sv */
module fra_unit
   import fra_pkg::*;
#(
   parameter  int VALUE_BITS = VALUE_BITS_DEF,
   localparam int NumW       = 2 * VALUE_BITS + 1,
   localparam int CntW       = $clog2(NumW + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  fra_unit_cmd_type cmd,
   input  logic [NumW-1:0]  opa,
   input  logic [NumW-1:0]  opb,
   output fra_unit_sts_type sts,
   output logic [NumW-1:0]  result
);

   typedef enum logic [3:0] {
      U_IDLE  = 4'b0001,
      U_ALIGN = 4'b0010,
      U_RUN   = 4'b0100,
      U_DIV   = 4'b1000
   } fra_ustate_type;

   fra_ustate_type  state_ff, state_in;
   logic            done_ff, done_in;
   logic [NumW-1:0] x_ff, x_in;
   logic [NumW-1:0] y_ff, y_in;
   logic [NumW-1:0] rem_ff, rem_in;
   logic [NumW-1:0] res_ff, res_in;
   logic [CntW-1:0] k_ff, k_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   logic [NumW:0]   rem_sh;
   logic [NumW+1:0] sub_lhs;
   logic [NumW+1:0] diff;
   logic [NumW+1:0] negd;
   logic            borrow;

   // one subtractor plus negation: gcd compare/difference or restoring divide step
   assign rem_sh  = {rem_ff, x_ff[NumW-1]};
   assign sub_lhs = (state_ff == U_DIV) ? {1'b0, rem_sh} : {2'b00, x_ff};
   assign diff    = sub_lhs - {2'b00, y_ff};
   assign negd    = '0 - diff;
   assign borrow  = diff[NumW+1];

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      x_in     = x_ff;
      y_in     = y_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               x_in   = opa;
               y_in   = opb;
               k_in   = '0;
               rem_in = '0;
               if (cmd.op == FRA_OP_DIV) begin
                  state_in = U_DIV;
                  if (cmd.short_op) begin
                     // narrow dividend: left-align so only its own bits are stepped
                     x_in   = {opa[VALUE_BITS-1:0], {(VALUE_BITS + 1){1'b0}}};
                     cnt_in = CntW'(VALUE_BITS);
                  end else begin
                     cnt_in = CntW'(NumW);
                  end
               end else begin
                  state_in = U_ALIGN;
               end
            end
         end
         U_ALIGN: begin
            // strip common factors of two
            if (x_ff != '0 && y_ff != '0 && !x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else begin
               state_in = U_RUN;
            end
         end
         U_RUN: begin
            priority if (x_ff == '0) begin
               res_in   = y_ff << k_ff;
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else if (y_ff == '0 || x_ff == y_ff) begin
               res_in   = x_ff << k_ff;
               done_in  = 1'b1;
               state_in = U_IDLE;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!borrow) begin
               x_in = diff[NumW-1:0] >> 1;
            end else begin
               y_in = negd[NumW-1:0] >> 1;
            end
         end
         U_DIV: begin
            x_in   = {x_ff[NumW-2:0], ~borrow};
            rem_in = borrow ? rem_sh[NumW-1:0] : diff[NumW-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               res_in   = {x_ff[NumW-2:0], ~borrow};
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
   end

   assign sts.done = done_ff;
   assign result   = res_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("unit done held for more than one cycle");

   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && state_ff == U_IDLE) |=> state_ff != U_IDLE)
      else $error("unit start not taken");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == U_DIV |-> y_ff != '0)
      else $error("division by zero in shared unit");
`endif

endmodule

/* bench/fra_sum_checker.sv */
`timescale 1ns / 1ps

module fra_sum_checker
   import fra_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [VALUE_BITS-1:0]   req_num_first,
   input  logic [VALUE_BITS-1:0]   req_den_first,
   input  logic [VALUE_BITS-1:0]   req_num_second,
   input  logic [VALUE_BITS-1:0]   req_den_second,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [2*VALUE_BITS:0]   rsp_sum_num,
   input  logic [2*VALUE_BITS-1:0] rsp_sum_den,
   output int                      fail_count,
   output int                      pending_count
);

   typedef struct packed {
      logic [2*VALUE_BITS:0]   num;
      logic [2*VALUE_BITS-1:0] den;
   } reduced_frac_type;

   reduced_frac_type sum_queue[$];
   int               mismatch_total = 0;
   int               waiting_total  = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = waiting_total;

   function automatic logic [63:0] common_factor(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // lcm of the denominators, cross-scaled numerators, then reduce by the gcd
   function automatic reduced_frac_type reduced_sum(input logic [VALUE_BITS-1:0] a,
                                                    input logic [VALUE_BITS-1:0] b,
                                                    input logic [VALUE_BITS-1:0] c,
                                                    input logic [VALUE_BITS-1:0] d);
      logic [63:0]      den_a, den_b, g, part_a, part_b, lcm, total, h, q_num, q_den;
      reduced_frac_type r;
      den_a  = (b == '0) ? 64'd1 : 64'(b);
      den_b  = (d == '0) ? 64'd1 : 64'(d);
      g      = common_factor(den_a, den_b);
      part_a = den_a / g;
      part_b = den_b / g;
      lcm    = part_a * den_b;
      total  = 64'(a) * part_b + 64'(c) * part_a;
      if (total == 0) begin
         r.num = '0;
         r.den = (2*VALUE_BITS)'(1);
      end else begin
         h     = common_factor(total, lcm);
         q_num = total / h;
         q_den = lcm / h;
         r.num = q_num[2*VALUE_BITS:0];
         r.den = q_den[2*VALUE_BITS-1:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reduced_frac_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (sum_queue.size() == 0) begin
               mismatch_total++;
               $display("%0t: unexpected result %0d/%0d", $time, rsp_sum_num, rsp_sum_den);
            end else begin
               want = sum_queue.pop_front();
               if (rsp_sum_num !== want.num) begin
                  mismatch_total++;
                  $display("%0t: sum_num expected %0d actual %0d", $time, want.num,
                           rsp_sum_num);
               end
               if (rsp_sum_den !== want.den) begin
                  mismatch_total++;
                  $display("%0t: sum_den expected %0d actual %0d", $time, want.den,
                           rsp_sum_den);
               end
            end
         end
         if (req_valid && req_ready)
            sum_queue.push_back(reduced_sum(req_num_first, req_den_first,
                                            req_num_second, req_den_second));
         waiting_total = sum_queue.size();
      end
   end

endmodule

/* bench/fraction_add_reduce_top_tb.sv */
`timescale 1ns / 1ps

module fraction_add_reduce_top_tb;
   import fra_pkg::*;

   localparam int VALUE_BITS   = VALUE_BITS_DEF;
   localparam int CLK_PERIOD   = 8;
   localparam int MAX_VALUE    = (1 << VALUE_BITS) - 1;
   localparam int RANDOM_ITEMS = 900;
   localparam int CALM_FROM    = 760;   // no idling on either side from here on
   localparam int HOLD_AT      = 200;   // transactions sent before the long back-pressure
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 400;   // worst-case latency plus margin

   logic clock = 1'b0;
   logic reset;

   // sender and receiver coordination
   int   sent_count = 0;
   bit   calm       = 1'b0;
   bit   hold_done  = 1'b0;
   int   fail_count;
   int   pending_count;

   fra_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   fra_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_bus ();

   fraction_add_reduce_top #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // watches both channels, predicts every sum and compares
   fra_sum_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) sum_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_num_first  (req_bus.num_first),
      .req_den_first  (req_bus.den_first),
      .req_num_second (req_bus.num_second),
      .req_den_second (req_bus.den_second),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_sum_num    (rsp_bus.sum_num),
      .rsp_sum_den    (rsp_bus.sum_den),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // offer one transaction from the falling edge and hold it until accepted
   task automatic send_pair(input logic [VALUE_BITS-1:0] a, input logic [VALUE_BITS-1:0] b,
                            input logic [VALUE_BITS-1:0] c, input logic [VALUE_BITS-1:0] d);
      @(negedge clock);
      req_bus.num_first  <= a;
      req_bus.den_first  <= b;
      req_bus.num_second <= c;
      req_bus.den_second <= d;
      req_bus.valid      <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sent_count++;
   endtask

   // a gap with valid low; n sets its length
   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   function automatic logic [VALUE_BITS-1:0] corner_value();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return 1;
         2:       return MAX_VALUE - 1;
         default: return MAX_VALUE;
      endcase
   endfunction

   // stimulus
   initial begin
      logic [VALUE_BITS-1:0] a, b, c, d;
      int                    g;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.num_first  = '0;
      req_bus.den_first  = 1;
      req_bus.num_second = '0;
      req_bus.den_second = 1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: zero sums, zero denominators, extremes, shared factors
      send_pair(0, 1, 0, 1);
      send_pair(0, 0, 0, 0);
      send_pair(1, 0, 1, 0);
      send_pair(5, 7, 0, 0);
      send_pair(MAX_VALUE, MAX_VALUE, MAX_VALUE, MAX_VALUE);
      send_pair(MAX_VALUE, 1, MAX_VALUE, 1);
      send_pair(MAX_VALUE, MAX_VALUE, MAX_VALUE, MAX_VALUE - 1);
      send_pair(1, MAX_VALUE, 1, MAX_VALUE - 1);
      send_pair(6, 12, 6, 12);          // common factor equal to a value
      send_pair(1, 2, 1, 2);
      send_pair(3, 4, 1, 4);
      send_pair(1, 3, 1, 6);            // one denominator divides the other
      send_pair(0, 7, 5, 7);
      send_pair(1, 1, 0, MAX_VALUE);
      send_pair(MAX_VALUE, 256, MAX_VALUE, 32768);
      send_pair(1, 32768, 1, 32768);
      send_pair(12, 18, 0, 9);
      send_pair(7, 1, 3, 1);
      send_pair(1, MAX_VALUE, 0, 1);
      send_pair(2, 4, 2, 8);
      send_pair(MAX_VALUE, 2, 1, 2);
      send_pair(MAX_VALUE - 1, 0, 1, MAX_VALUE);

      // random part, mixed shapes of operands
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= CALM_FROM);
         if (!calm && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 14));
         case ($urandom_range(0, 9))
            4, 5: begin
               // denominators sharing a sizeable factor
               g = $urandom_range(1, 255);
               a = VALUE_BITS'($urandom_range(0, MAX_VALUE));
               c = VALUE_BITS'($urandom_range(0, MAX_VALUE));
               b = VALUE_BITS'(g * $urandom_range(1, 255));
               d = VALUE_BITS'(g * $urandom_range(1, 255));
            end
            6: begin
               a = VALUE_BITS'($urandom_range(0, 16));
               b = VALUE_BITS'($urandom_range(0, 16));
               c = VALUE_BITS'($urandom_range(0, 16));
               d = VALUE_BITS'($urandom_range(0, 16));
            end
            7: begin
               a = VALUE_BITS'($urandom_range(0, MAX_VALUE));
               c = VALUE_BITS'($urandom_range(0, MAX_VALUE));
               b = VALUE_BITS'(1 << $urandom_range(0, VALUE_BITS - 1));
               d = VALUE_BITS'(1 << $urandom_range(0, VALUE_BITS - 1));
            end
            8: begin
               // equal denominators with a sum that cancels to a whole number
               b = VALUE_BITS'($urandom_range(1, MAX_VALUE));
               a = VALUE_BITS'($urandom_range(0, MAX_VALUE));
               c = b - (a % b);
               d = b;
            end
            9: begin
               a = corner_value();
               b = corner_value();
               c = corner_value();
               d = corner_value();
            end
            default: begin
               a = VALUE_BITS'($urandom_range(0, MAX_VALUE));
               b = VALUE_BITS'($urandom_range(0, MAX_VALUE));
               c = VALUE_BITS'($urandom_range(0, MAX_VALUE));
               d = VALUE_BITS'($urandom_range(0, MAX_VALUE));
            end
         endcase
         send_pair(a, b, c, d);
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // drain: every expected sum back, then a latency's worth of quiet
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** fraction_add_reduce_top: PASSED **");
      else
         $display("** fraction_add_reduce_top: FAILED **");
      $finish;
   end

   // receiver: random ready bursts, one long hold-off so the block backs up
   initial begin
      bit level;
      int span;
      rsp_bus.ready = 1'b0;
      forever begin
         if (!hold_done && sent_count >= HOLD_AT) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
            end
         end else begin
            level = calm || ($urandom_range(0, 2) != 0);
            span  = $urandom_range(1, 14);
            repeat (span) begin
               @(negedge clock);
               rsp_bus.ready <= level;
            end
         end
      end
   end

   // watchdog, several times the slowest legal run
   initial begin
      #(CLK_PERIOD * 800000);
      $display("** fraction_add_reduce_top: FAILED **");
      $finish;
   end

endmodule

/* filelist.f */
src/fra_pkg.sv
src/fra_req_if.sv
src/fra_rsp_if.sv
src/fra_unit.sv
src/fraction_add_reduce_top.sv
bench/fra_sum_checker.sv
bench/fraction_add_reduce_top_tb.sv
